// ===== src/lph_pkg.sv =====
// shared constants, codes and state type of the linear probe hash table
package lph_pkg;

  // default number of slots
  localparam int TABLE_SIZE = 16;

  // payload widths
  localparam int OP_W    = 2;
  localparam int KEY_W   = 31;
  localparam int STAT_W  = 2;
  localparam int PROBE_W = 5;
  localparam int SLOT_W  = 4;

  // operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_FIND   = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_MISS = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

  // width of one key digit in the modulo reduction
  localparam int DIGIT_W = 4;

  // controller states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_PROBE
  } state_t;

endpackage

// ===== src/lph_if.sv =====
// request and response channel interfaces of the linear probe hash table

interface lph_req_if;
  logic                        valid;
  logic                        ready;
  logic [lph_pkg::OP_W-1:0]    op;
  logic [lph_pkg::KEY_W-1:0]   key;

  modport source (output valid, op, key, input ready);
  modport sink   (input valid, op, key, output ready);
endinterface

interface lph_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [lph_pkg::STAT_W-1:0]   status;
  logic [lph_pkg::PROBE_W-1:0]  probe_count;
  logic [lph_pkg::SLOT_W-1:0]   slot_index;

  modport source (output valid, status, probe_count, slot_index, input ready);
  modport sink   (input valid, status, probe_count, slot_index, output ready);
endinterface

// ===== src/lph_ram.sv =====
// generic single write, single read port ram with registered read data
module lph_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== src/linear_probe_hash_table_unit.sv =====
// open addressing hash table with linear probing, slots held in one ram
//
//   channel  dir   beat payload                        handshake
//   req      in    op (2), key (31)                    valid / ready
//   rsp      out   status (2), probe_count (5),        valid / ready
//                  slot_index (4)
//
// after reset a clearing pass writes every slot empty; req.ready is low then
// one item at a time: while probing and not held by a waiting result, the ram gives one
//   slot per cycle; the next beat is taken only once the result of the item is loaded
//   into the output register; an item reads at most TABLE_SIZE slots
// a table size that is not a power of two adds a key reduction before the probe, one digit a cycle
// a result waiting in the output register lets the next beat in; a probe that is ready
//   to finish holds while that result is still not taken
module linear_probe_hash_table_unit #(
  parameter int TABLE_SIZE = lph_pkg::TABLE_SIZE
) (
  input  logic      clk,
  input  logic      rst,
  lph_req_if.sink   req,
  lph_rsp_if.source rsp
);

  localparam int  IDX_W   = $clog2(TABLE_SIZE);
  localparam int  CNT_W   = $clog2(TABLE_SIZE + 1);
  localparam int  WORD_W  = lph_pkg::KEY_W + 1;
  localparam int  RED_W   = IDX_W + lph_pkg::DIGIT_W;
  localparam int  DIGITS  = WORD_W / lph_pkg::DIGIT_W;
  localparam bit  POW2    = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;
  localparam logic [IDX_W-1:0] LAST_SLOT  = IDX_W'(TABLE_SIZE - 1);
  localparam logic [CNT_W-1:0] SWEEP      = CNT_W'(TABLE_SIZE);
  localparam logic [2:0]       LAST_DIGIT = 3'(DIGITS - 1);

  lph_pkg::state_t state, state_next;

  // item registers
  logic [lph_pkg::OP_W-1:0]  op_r;
  logic [lph_pkg::KEY_W-1:0] key_r;
  logic [IDX_W-1:0]          chk_pos, chk_pos_next;
  logic [CNT_W-1:0]          probes, probes_next;
  logic [IDX_W-1:0]          clr_idx;

  // key reduction registers
  logic [WORD_W-1:0]         hash_sr;
  logic [IDX_W-1:0]          rem, rem_next;
  logic [2:0]                hcnt;

  // output register
  logic                         out_valid;
  logic [lph_pkg::STAT_W-1:0]   out_status;
  logic [lph_pkg::PROBE_W-1:0]  out_probes;
  logic [lph_pkg::SLOT_W-1:0]   out_slot;

  // ram ports
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  // result of the deciding probe
  logic                        load_out;
  logic [lph_pkg::STAT_W-1:0]  res_status;
  logic [CNT_W-1:0]            res_probes;
  logic [IDX_W-1:0]            res_slot;
  logic [CNT_W+lph_pkg::PROBE_W-1:0] probes_ext;
  logic [IDX_W+lph_pkg::SLOT_W-1:0]  slot_ext;

  // probe helpers
  logic             slot_full, slot_match, last_probe, can_emit, done;
  logic [CNT_W-1:0] probes_inc;
  logic [IDX_W-1:0] pos_inc;

  lph_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_SIZE)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign req.ready       = (state == lph_pkg::ST_IDLE);
  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.probe_count = out_probes;
  assign rsp.slot_index  = out_slot;

  // one digit of key modulo table size: shift in a digit, then conditional subtracts
  always_comb begin
    logic [RED_W-1:0] w;
    logic [RED_W-1:0] dv;
    w = {rem, hash_sr[WORD_W-1 -: lph_pkg::DIGIT_W]};
    for (int k = lph_pkg::DIGIT_W - 1; k >= 0; k--) begin
      dv = RED_W'(TABLE_SIZE) << k;
      if (w >= dv) begin
        w = w - dv;
      end
    end
    rem_next = w[IDX_W-1:0];
  end

  // probe status of the slot returned by the ram
  assign slot_full  = ram_rdata[WORD_W-1];
  assign slot_match = slot_full && (ram_rdata[lph_pkg::KEY_W-1:0] == key_r);
  assign probes_inc = probes + CNT_W'(1);
  assign last_probe = (probes_inc == SWEEP);
  assign pos_inc    = (chk_pos == LAST_SLOT) ? '0 : chk_pos + IDX_W'(1);
  assign can_emit   = !out_valid || rsp.ready;

  // next state, ram control and result
  always_comb begin
    state_next   = state;
    chk_pos_next = chk_pos;
    probes_next  = probes;
    ram_raddr    = chk_pos;
    ram_we       = 1'b0;
    ram_waddr    = chk_pos;
    ram_wdata    = {1'b1, key_r};
    load_out     = 1'b0;
    done         = 1'b0;
    res_status   = lph_pkg::STAT_MISS;
    res_probes   = probes;
    res_slot     = '0;
    unique case (state)
      lph_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx;
        ram_wdata = '0;
        if (clr_idx == LAST_SLOT) begin
          state_next = lph_pkg::ST_IDLE;
        end
      end
      lph_pkg::ST_IDLE: begin
        ram_raddr = req.key[IDX_W-1:0];
        if (req.valid) begin
          chk_pos_next = req.key[IDX_W-1:0];
          probes_next  = '0;
          state_next   = POW2 ? lph_pkg::ST_PROBE : lph_pkg::ST_HASH;
        end
      end
      lph_pkg::ST_HASH: begin
        ram_raddr = rem_next;
        if (hcnt == LAST_DIGIT) begin
          chk_pos_next = rem_next;
          state_next   = lph_pkg::ST_PROBE;
        end
      end
      lph_pkg::ST_PROBE: begin
        unique case (op_r)
          lph_pkg::OP_INSERT: begin
            if (!slot_full) begin
              done       = 1'b1;
              res_status = lph_pkg::STAT_OK;
              res_slot   = chk_pos;
              ram_we     = can_emit;
              ram_wdata  = {1'b1, key_r};
            end else if (last_probe) begin
              done       = 1'b1;
              res_status = lph_pkg::STAT_FULL;
              res_probes = probes_inc;
            end
          end
          lph_pkg::OP_FIND, lph_pkg::OP_DELETE: begin
            if (slot_match) begin
              done       = 1'b1;
              res_status = lph_pkg::STAT_OK;
              res_slot   = chk_pos;
              ram_we     = can_emit && (op_r == lph_pkg::OP_DELETE);
              ram_wdata  = {1'b0, key_r};
            end else if (!slot_full) begin
              done = 1'b1;
            end else if (last_probe) begin
              done       = 1'b1;
              res_probes = probes_inc;
            end
          end
          default: begin
            // unused code: no operation, plain miss
            done       = 1'b1;
            res_probes = '0;
          end
        endcase
        if (!done) begin
          // read ahead of the next slot while this one is checked
          ram_raddr    = pos_inc;
          chk_pos_next = pos_inc;
          probes_next  = probes_inc;
        end else if (can_emit) begin
          load_out   = 1'b1;
          state_next = lph_pkg::ST_IDLE;
        end else begin
          // re-read the same slot so its data is there next cycle
          ram_raddr = chk_pos;
        end
      end
      default: begin
        state_next = lph_pkg::ST_CLEAR;
      end
    endcase
  end

  assign probes_ext = {{lph_pkg::PROBE_W{1'b0}}, res_probes};
  assign slot_ext   = {{lph_pkg::SLOT_W{1'b0}}, res_slot};

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lph_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // control counters and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx   <= '0;
      hcnt      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == lph_pkg::ST_CLEAR) begin
        clr_idx <= clr_idx + IDX_W'(1);
      end
      if (state == lph_pkg::ST_HASH) begin
        hcnt <= hcnt + 3'd1;
      end else begin
        hcnt <= '0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    chk_pos <= chk_pos_next;
    probes  <= probes_next;
    if (state == lph_pkg::ST_IDLE && req.valid) begin
      op_r    <= req.op;
      key_r   <= req.key;
      hash_sr <= {1'b0, req.key};
      rem     <= '0;
    end else if (state == lph_pkg::ST_HASH) begin
      hash_sr <= hash_sr << lph_pkg::DIGIT_W;
      rem     <= rem_next;
    end
    if (load_out) begin
      out_status <= res_status;
      out_probes <= probes_ext[lph_pkg::PROBE_W-1:0];
      out_slot   <= slot_ext[lph_pkg::SLOT_W-1:0];
    end
  end

endmodule

// ===== src/lph_checker.sv =====
// port level checks of the linear probe hash table and their binding
module lph_checker #(
  parameter int TABLE_SIZE = lph_pkg::TABLE_SIZE
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic [lph_pkg::STAT_W-1:0]   rsp_status,
  input logic [lph_pkg::PROBE_W-1:0]  rsp_probe_count,
  input logic [lph_pkg::SLOT_W-1:0]   rsp_slot_index
);

  localparam logic [lph_pkg::PROBE_W-1:0] SWEEP = lph_pkg::PROBE_W'(TABLE_SIZE);

  // a result beat stays offered until taken
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped before it was taken");

  // one item at a time: an accepted beat makes the block busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken again while an item is in work");

  // a full table is reported only after a whole sweep
  a_full_sweep: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == lph_pkg::STAT_FULL |-> rsp_probe_count == SWEEP)
    else $error("table full reported without a whole sweep");

  // an unsuccessful result carries slot zero
  a_fail_slot: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != lph_pkg::STAT_OK |-> rsp_slot_index == '0)
    else $error("nonzero slot on an unsuccessful result");

endmodule

bind linear_probe_hash_table_unit lph_checker #(
  .TABLE_SIZE (TABLE_SIZE)
) u_lph_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_status      (rsp.status),
  .rsp_probe_count (rsp.probe_count),
  .rsp_slot_index  (rsp.slot_index)
);
